// File: rtl/core/wnps_pkg.sv
package wnps_pkg;

  localparam int IDX_W   = 8;
  localparam int VAL_W   = 16;
  localparam int COORD_W = 15;
  localparam int ENTRY_W = 64;
  localparam int CNT_CFG_W = 9;

  localparam int MAG_W  = 16;
  localparam int DIFF_W = 17;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 35;
  localparam int DIST_W = 33;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam int VAL_LSB = 0;
  localparam int ARO_LSB = 16;
  localparam int DOM_LSB = 32;
  localparam int INT_LSB = 48;

  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;

  localparam logic [PADDR_W-1:0] ADDR_NODE_COUNT = '0;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [2:0] STEP_LAST_DIFF = 3'd3;
  localparam logic [2:0] STEP_FIRST_ACC = 3'd2;
  localparam logic [2:0] STEP_LAST      = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CALC,
    ST_CMP,
    ST_DONE
  } state_e;

endpackage

// File: rtl/core/wnps_if.sv
interface wnps_in_if
  import wnps_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [IDX_W-1:0]          entry_index;
  logic signed [VAL_W-1:0]   valence;
  logic [COORD_W-1:0]        arousal;
  logic [COORD_W-1:0]        dominance;
  logic [COORD_W-1:0]        intensity;

  modport source (
    output valid, mode, entry_index, valence, arousal, dominance, intensity,
    input  ready
  );
  modport sink (
    input  valid, mode, entry_index, valence, arousal, dominance, intensity,
    output ready
  );
endinterface

interface wnps_out_if
  import wnps_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                found;
  logic [IDX_W-1:0]    nearest_index;
  logic [DIST_W-1:0]   min_distance_sq;

  modport source (
    output valid, found, nearest_index, min_distance_sq,
    input  ready
  );
  modport sink (
    input  valid, found, nearest_index, min_distance_sq,
    output ready
  );
endinterface

// File: rtl/core/weighted_nearest_point_search_unit.sv
// Weighted nearest point search over a table of four-coordinate points.
// The input channel carries two kinds of items. A load item (mode 0) writes
// one table entry in the cycle it is accepted and gives no result. A query
// item (mode 1) scans entries 0 to min(node_count, MAX_ENTRIES)-1 and
// returns one result: the entry with the least distance 2*dv^2 + 2*da^2 +
// dd^2 + di^2, lowest index on ties, with found cleared for an empty table.
// The user writes node_count through the APB port at address 0 only while
// the block is idle; the block itself does not enforce this. It reads
// back at the same address. A query steps each entry through ST_FETCH,
// ST_CALC and ST_CMP, then waits in ST_DONE for a free output register; an
// empty table goes straight to ST_DONE. Each entry takes one table read,
// six steps of the single shared 16x16 squaring multiplier with its
// difference and accumulate stages, and one compare.
// The input is ready only while no query is being worked on. A finished
// result waits in the output register; the next item is accepted while it
// waits, and a later query holds its result until the receiver takes the
// earlier one.
// Reset clears node_count, the sequencer and the output valid flag. The
// table is not cleared and must be loaded before it is searched.
module weighted_nearest_point_search_unit
  import wnps_pkg::*;
#(
  parameter int MAX_ENTRIES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  wnps_in_if.sink             in_i,
  wnps_out_if.source          out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic [ENTRY_W-1:0] table_mem [MAX_ENTRIES];

  state_e                state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         lim_q, lim_d;
  logic [2:0]            step_q, step_d;
  logic [CNT_CFG_W-1:0]  node_count_q;
  logic                  out_valid_q, out_valid_d;
  logic                  best_found_q, best_found_d;

  logic signed [VAL_W-1:0] qv_q;
  logic [COORD_W-1:0]      qa_q, qd_q, qi_q;
  logic [ENTRY_W-1:0]      rdata_q;
  logic [MAG_W-1:0]        diff_q;
  logic [PROD_W-1:0]       prod_q;
  logic [ACC_W-1:0]        acc_q, acc_d;
  logic [IDX_W-1:0]        best_idx_q, best_idx_d;
  logic [DIST_W-1:0]       best_dist_q, best_dist_d;
  logic                    out_found_q;
  logic [IDX_W-1:0]        out_idx_q;
  logic [DIST_W-1:0]       out_dist_q;

  logic                    in_xfer, load_xfer, query_xfer, out_free, cfg_wr, load_ok;
  logic                    nc_sel;
  logic [31:0]             idx_ext, nc_ext;
  logic signed [DIFF_W-1:0] op_a, op_b, diff_full;
  logic [MAG_W-1:0]        mag;
  logic [ACC_W-1:0]        term;
  logic [DIST_W-1:0]       dist_sat;
  logic                    better;
  logic [CW-1:0]           cnt_inc;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign load_xfer   = in_xfer && (in_i.mode == MODE_LOAD);
  assign query_xfer  = in_xfer && (in_i.mode == MODE_QUERY);
  assign out_free    = !out_valid_q || out_o.ready;
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign nc_sel      = (paddr == ADDR_NODE_COUNT);

  assign idx_ext = 32'(in_i.entry_index);
  assign load_ok = idx_ext < 32'(MAX_ENTRIES);
  assign nc_ext  = 32'(node_count_q);
  assign lim_d   = (nc_ext > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(nc_ext);
  assign cnt_inc = cnt_q + CW'(1);

  assign pready = 1'b1;
  assign prdata = nc_sel ? PDATA_W'(node_count_q) : '0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (query_xfer) begin
          state_d = (node_count_q == '0) ? ST_DONE : ST_FETCH;
        end
      end
      ST_FETCH: state_d = ST_CALC;
      ST_CALC: begin
        if (step_q == STEP_LAST) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: state_d = (cnt_inc == lim_q) ? ST_DONE : ST_FETCH;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    case (step_q[1:0])
      2'd0: begin
        op_a = DIFF_W'(qv_q);
        op_b = DIFF_W'($signed(rdata_q[VAL_LSB +: VAL_W]));
      end
      2'd1: begin
        op_a = DIFF_W'(qa_q);
        op_b = DIFF_W'(rdata_q[ARO_LSB +: COORD_W]);
      end
      2'd2: begin
        op_a = DIFF_W'(qd_q);
        op_b = DIFF_W'(rdata_q[DOM_LSB +: COORD_W]);
      end
      default: begin
        op_a = DIFF_W'(qi_q);
        op_b = DIFF_W'(rdata_q[INT_LSB +: COORD_W]);
      end
    endcase
    diff_full = op_a - op_b;
    mag = diff_full[DIFF_W-1] ? MAG_W'(-diff_full) : diff_full[MAG_W-1:0];
  end

  assign term     = (step_q <= STEP_LAST_DIFF) ? (ACC_W'(prod_q) << 1) : ACC_W'(prod_q);
  assign dist_sat = (acc_q > ACC_W'(DIST_MAX)) ? DIST_MAX : acc_q[DIST_W-1:0];
  assign better   = !best_found_q || (dist_sat < best_dist_q);

  always_comb begin
    cnt_d        = cnt_q;
    step_d       = step_q;
    acc_d        = acc_q;
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_dist_d  = best_dist_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    case (state_q)
      ST_IDLE: begin
        if (query_xfer) begin
          cnt_d        = '0;
          best_found_d = 1'b0;
          best_idx_d   = '0;
          best_dist_d  = '0;
        end
      end
      ST_FETCH: step_d = '0;
      ST_CALC: begin
        step_d = step_q + 3'd1;
        if (step_q >= STEP_FIRST_ACC) begin
          acc_d = ((step_q == STEP_FIRST_ACC) ? '0 : acc_q) + term;
        end
      end
      ST_CMP: begin
        cnt_d = cnt_inc;
        if (better) begin
          best_found_d = 1'b1;
          best_idx_d   = IDX_W'(cnt_q);
          best_dist_d  = dist_sat;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      step_q       <= '0;
      node_count_q <= '0;
      out_valid_q  <= 1'b0;
      best_found_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      step_q       <= step_d;
      out_valid_q  <= out_valid_d;
      best_found_q <= best_found_d;
      if (cfg_wr && nc_sel) begin
        node_count_q <= pwdata[CNT_CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    best_idx_q  <= best_idx_d;
    best_dist_q <= best_dist_d;
    if (query_xfer) begin
      qv_q  <= in_i.valence;
      qa_q  <= in_i.arousal;
      qd_q  <= in_i.dominance;
      qi_q  <= in_i.intensity;
      lim_q <= lim_d;
    end
    if (state_q == ST_CALC) begin
      if (step_q <= STEP_LAST_DIFF) begin
        diff_q <= mag;
      end
      prod_q <= PROD_W'(diff_q) * PROD_W'(diff_q);
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_found_q <= best_found_q;
      out_idx_q   <= best_idx_q;
      out_dist_q  <= best_dist_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_xfer && load_ok) begin
      table_mem[idx_ext[AW-1:0]] <= {1'b0, in_i.intensity, 1'b0, in_i.dominance,
                                     1'b0, in_i.arousal, in_i.valence};
    end
    if (state_q == ST_FETCH) begin
      rdata_q <= table_mem[cnt_q[AW-1:0]];
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.found           = out_found_q;
  assign out_o.nearest_index   = out_idx_q;
  assign out_o.min_distance_sq = out_dist_q;

endmodule

// File: rtl/core/wnps_checker.sv
module wnps_checker
  import wnps_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               in_mode_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               out_found_i,
  input logic [IDX_W-1:0]   out_index_i,
  input logic [DIST_W-1:0]  out_dist_i
);

  // A result that is not taken stays, unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_found_i)
      && $stable(out_index_i) && $stable(out_dist_i))
    else $error("stalled result changed");

  // A query occupies the block, so the input drops after its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_mode_i == MODE_QUERY) |=> !in_ready_i)
    else $error("input ready after query transfer");

  // An empty search reports zero index and distance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_found_i |-> (out_index_i == '0) && (out_dist_i == '0))
    else $error("empty result has nonzero fields");

  // A load never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_mode_i == MODE_LOAD) && !out_valid_i |=> !out_valid_i)
    else $error("result after load transfer");

endmodule

bind weighted_nearest_point_search_unit wnps_checker u_wnps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_found_i (out_o.found),
  .out_index_i (out_o.nearest_index),
  .out_dist_i  (out_o.min_distance_sq)
);

// File: tb/tb.sv
module tb
  import wnps_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TABLE_DEPTH = 256;
  localparam int unsigned IDLE_MAX    = 14;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic                    mode;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] valence;
    logic [COORD_W-1:0]      arousal;
    logic [COORD_W-1:0]      dominance;
    logic [COORD_W-1:0]      intensity;
  } point_item_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  nearest_index;
    logic [DIST_W-1:0] min_distance_sq;
  } search_result_t;

  logic               clk = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  wnps_in_if  in_ch ();
  wnps_out_if out_ch ();

  weighted_nearest_point_search_unit #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) uut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [ENTRY_W-1:0]   point_mem [TABLE_DEPTH];
  bit                   loaded [TABLE_DEPTH];
  logic [CNT_CFG_W-1:0] cfg_count = '0;
  search_result_t       result_q [$];
  bit                   no_idle = 1'b0;
  int unsigned          errors = 0;
  int unsigned          cycle_count = 0;
  int unsigned          n_loads = 0;
  int unsigned          n_queries = 0;
  int unsigned          n_empty = 0;
  int unsigned          n_saturated = 0;

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned idle_cycles();
    return no_idle ? 0 : $urandom_range(0, IDLE_MAX);
  endfunction

  function automatic logic [DIST_W-1:0] weighted_dist_sq(logic [ENTRY_W-1:0] e,
                                                        point_item_t q);
    longint dv, da, dd, di, s;
    dv = longint'($signed(q.valence)) - longint'($signed(e[VAL_LSB +: VAL_W]));
    da = longint'(q.arousal) - longint'(e[ARO_LSB +: COORD_W]);
    dd = longint'(q.dominance) - longint'(e[DOM_LSB +: COORD_W]);
    di = longint'(q.intensity) - longint'(e[INT_LSB +: COORD_W]);
    s  = 2 * dv * dv + 2 * da * da + dd * dd + di * di;
    if (s > longint'(DIST_MAX)) begin
      return DIST_MAX;
    end
    return s[DIST_W-1:0];
  endfunction

  function automatic search_result_t nearest_entry(point_item_t q);
    search_result_t    r;
    int                n;
    logic [DIST_W-1:0] d_sq;
    r = '0;
    n = (cfg_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cfg_count);
    for (int k = 0; k < n; k++) begin
      d_sq = weighted_dist_sq(point_mem[k], q);
      if (!r.found || d_sq < r.min_distance_sq) begin
        r.found           = 1'b1;
        r.min_distance_sq = d_sq;
        r.nearest_index   = k[IDX_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic point_item_t mk_item(logic mode, logic [IDX_W-1:0] idx,
                                          logic signed [VAL_W-1:0] v,
                                          logic [COORD_W-1:0] a,
                                          logic [COORD_W-1:0] d,
                                          logic [COORD_W-1:0] i);
    point_item_t it;
    it.mode        = mode;
    it.entry_index = idx;
    it.valence     = v;
    it.arousal     = a;
    it.dominance   = d;
    it.intensity   = i;
    return it;
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_valence();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 16'shC000;
          1: v = 16'sh4000;
          2: v = '0;
          3: v = 16'sh8000;
          default: v = 16'sh7FFF;
        endcase
      end
      1, 2: v = VAL_W'($urandom);
      default: v = VAL_W'($urandom_range(0, 32768)) - 16'sh4000;
    endcase
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    logic [COORD_W-1:0] c;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 2))
          0: c = '0;
          1: c = 15'd16384;
          default: c = 15'h7FFF;
        endcase
      end
      1, 2: c = COORD_W'($urandom);
      default: c = COORD_W'($urandom_range(0, 16384));
    endcase
    return c;
  endfunction

  function automatic point_item_t rand_point(logic mode, logic [IDX_W-1:0] idx);
    return mk_item(mode, idx, rand_valence(), rand_coord(), rand_coord(), rand_coord());
  endfunction

  // Loads mostly hit the searched range and sometimes copy an entry to make ties;
  // queries often land close to a stored point so the compare sees close races.
  function automatic point_item_t random_item(int n);
    point_item_t        it;
    logic [ENTRY_W-1:0] e;
    int                 span;
    span = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
    if ($urandom_range(0, 99) < 35) begin
      it = rand_point(MODE_LOAD, IDX_W'(($urandom_range(0, 4) == 0) ?
                      $urandom_range(0, TABLE_DEPTH - 1) : $urandom_range(0, span - 1)));
      if ($urandom_range(0, 4) == 0) begin
        e = point_mem[$urandom_range(0, span - 1)];
        it.valence   = e[VAL_LSB +: VAL_W];
        it.arousal   = e[ARO_LSB +: COORD_W];
        it.dominance = e[DOM_LSB +: COORD_W];
        it.intensity = e[INT_LSB +: COORD_W];
      end
    end else begin
      it = rand_point(MODE_QUERY, IDX_W'($urandom));
      if ($urandom_range(0, 9) < 4) begin
        e = point_mem[$urandom_range(0, span - 1)];
        it.valence   = e[VAL_LSB +: VAL_W] + VAL_W'($urandom_range(0, 128)) - 16'd64;
        it.arousal   = e[ARO_LSB +: COORD_W] + COORD_W'($urandom_range(0, 128)) - 15'd64;
        it.dominance = e[DOM_LSB +: COORD_W] + COORD_W'($urandom_range(0, 128)) - 15'd64;
        it.intensity = e[INT_LSB +: COORD_W] + COORD_W'($urandom_range(0, 128)) - 15'd64;
      end
    end
    return it;
  endfunction

  task automatic send_item(point_item_t it);
    int unsigned    gap;
    search_result_t r;
    gap = idle_cycles();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= it.mode;
    in_ch.entry_index <= it.entry_index;
    in_ch.valence     <= it.valence;
    in_ch.arousal     <= it.arousal;
    in_ch.dominance   <= it.dominance;
    in_ch.intensity   <= it.intensity;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (it.mode == MODE_LOAD) begin
      point_mem[it.entry_index] = {1'b0, it.intensity, 1'b0, it.dominance,
                                   1'b0, it.arousal, it.valence};
      loaded[it.entry_index]    = 1'b1;
      n_loads++;
    end else begin
      r = nearest_entry(it);
      result_q = {result_q, r};
      n_queries++;
      if (!r.found) n_empty++;
      if (r.found && r.min_distance_sq == DIST_MAX) n_saturated++;
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain_results();
    repeat (8) @(posedge clk);
  endtask

  task automatic write_node_count(logic [PDATA_W-1:0] raw);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_NODE_COUNT;
    pwdata  <= raw;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cfg_count = raw[CNT_CFG_W-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[CNT_CFG_W-1:0] !== cfg_count) begin
      $error("node_count readback: expected %0d, got %0d", cfg_count,
             prdata[CNT_CFG_W-1:0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic fill_missing(int n);
    int span;
    span = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
    for (int k = 0; k < span; k++) begin
      if (!loaded[k]) send_item(rand_point(MODE_LOAD, k[IDX_W-1:0]));
    end
  endtask

  task automatic test_empty_table();
    send_item(rand_point(MODE_QUERY, IDX_W'($urandom)));
    write_node_count(0);
    send_item(mk_item(MODE_QUERY, 8'd255, -16'sd16384, 15'd16384, 15'd0, 15'd16384));
  endtask

  task automatic test_single_entry();
    send_item(mk_item(MODE_LOAD, 8'd0, 16'sd16384, 15'd16384, 15'd0, 15'd16384));
    send_item(mk_item(MODE_LOAD, 8'd255, -16'sd16384, 15'd0, 15'd16384, 15'd0));
    write_node_count(1);
    send_item(mk_item(MODE_QUERY, 8'd0, 16'sd16384, 15'd16384, 15'd0, 15'd16384));
    send_item(mk_item(MODE_QUERY, 8'd0, -16'sd16384, 15'd0, 15'd16384, 15'd0));
    send_item(mk_item(MODE_QUERY, 8'd0, 16'sd0, 15'd0, 15'd0, 15'd0));
    send_item(rand_point(MODE_QUERY, IDX_W'($urandom)));
  endtask

  task automatic test_ties();
    send_item(mk_item(MODE_LOAD, 8'd1, 16'sd1000, 15'd2000, 15'd3000, 15'd4000));
    send_item(mk_item(MODE_LOAD, 8'd2, 16'sd1000, 15'd2000, 15'd3000, 15'd4000));
    send_item(mk_item(MODE_LOAD, 8'd3, 16'sd1000, 15'd2000, 15'd3014, 15'd4000));
    write_node_count(4);
    send_item(mk_item(MODE_QUERY, 8'd0, 16'sd1000, 15'd2000, 15'd3000, 15'd4000));
    send_item(mk_item(MODE_QUERY, 8'd0, 16'sd1000, 15'd2000, 15'd3007, 15'd4000));
  endtask

  task automatic test_saturation();
    send_item(mk_item(MODE_LOAD, 8'd0, 16'sh8000, 15'h7FFF, 15'h7FFF, 15'h7FFF));
    send_item(mk_item(MODE_LOAD, 8'd1, 16'sh8000, 15'h7FFF, 15'h7FFF, 15'h7FFF));
    write_node_count(2);
    send_item(mk_item(MODE_QUERY, 8'd0, 16'sh7FFF, 15'd0, 15'd0, 15'd0));
    send_item(mk_item(MODE_QUERY, 8'd0, 16'sh8000, 15'h7FFF, 15'h7FFF, 15'h7FFF));
  endtask

  task automatic test_random_small();
    int unsigned n;
    for (int round = 0; round < 16; round++) begin
      n = (round == 0) ? 1 : $urandom_range(1, 24);
      no_idle = ($urandom_range(0, 3) == 0);
      if (round == 5) begin
        write_node_count(($urandom & 32'hFFFF_FE00) | n);
      end else begin
        write_node_count(n);
      end
      fill_missing(n);
      for (int k = 0; k < 40; k++) begin
        send_item(random_item(n));
        if ($urandom_range(0, 29) == 0) drain_results();
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_full_table();
    write_node_count(TABLE_DEPTH);
    fill_missing(TABLE_DEPTH);
    for (int k = 0; k < 8; k++) send_item(random_item(TABLE_DEPTH));
    write_node_count(511);
    for (int k = 0; k < 5; k++) send_item(random_item(TABLE_DEPTH));
    write_node_count(300);
    for (int k = 0; k < 4; k++) send_item(random_item(TABLE_DEPTH));
  endtask

  initial begin : result_check
    int unsigned    hold;
    search_result_t got;
    search_result_t want;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_ni) @(posedge clk);
    forever begin
      hold = idle_cycles();
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got.found           = out_ch.found;
      got.nearest_index   = out_ch.nearest_index;
      got.min_distance_sq = out_ch.min_distance_sq;
      if (result_q.size() == 0) begin
        $error("result transfer with no search pending");
        errors++;
      end else begin
        want = result_q.pop_front();
        if (got.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, got.found);
          errors++;
        end
        if (got.nearest_index !== want.nearest_index) begin
          $error("nearest_index: expected %0d, got %0d", want.nearest_index,
                 got.nearest_index);
          errors++;
        end
        if (got.min_distance_sq !== want.min_distance_sq) begin
          $error("min_distance_sq: expected %0d, got %0d", want.min_distance_sq,
                 got.min_distance_sq);
          errors++;
        end
      end
    end
  end

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_LOAD;
    in_ch.entry_index <= '0;
    in_ch.valence     <= '0;
    in_ch.arousal     <= '0;
    in_ch.dominance   <= '0;
    in_ch.intensity   <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= ADDR_NODE_COUNT;
    pwdata            <= '0;
    rst_ni            <= 1'b0;
    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_single_entry();
    test_ties();
    test_saturation();
    test_random_small();
    test_full_table();
    settle();
    repeat (16) @(posedge clk);
    if (result_q.size() != 0) begin
      $error("%0d search results never arrived", result_q.size());
      errors++;
    end
    $display("Sent %0d table loads and %0d searches over counts from 0 to 511.",
             n_loads, n_queries);
    $display("Of the searches, %0d hit an empty table and %0d saturated the distance.",
             n_empty, n_saturated);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
